// ===== rtl/wii_pkg.sv =====
// ============================================================================
// wii_pkg
// Shared widths, register codes, types and helpers of the windowed integer
// integrator.
// ============================================================================
package wii_pkg;

    // sample store depth and derived widths
    localparam int WINDOW_DEPTH = 1024;
    localparam int ADDR_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W        = FILL_W + 1;

    // fixed field widths
    localparam int DATA_W      = 32;
    localparam int ACC_W       = 64;
    localparam int LEN_W       = 11;
    localparam int LIMIT_W     = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int CNT_W       = (FILL_W > LEN_W) ? FILL_W : LEN_W;
    localparam int REM_W       = DATA_W + 1;
    localparam int DIV_CNT_W   = $clog2(ACC_W);

    localparam int DEFAULT_WINDOW_LENGTH = 100;

    // scalar types
    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [ACC_W:0]    wide_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [FILL_W-1:0]        fill_t;
    typedef logic [SUM_W-1:0]         sum_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [LEN_W-1:0]         len_t;
    typedef logic [LIMIT_W-1:0]       limit_t;
    typedef logic [CFG_INDEX_W-1:0]   cfg_index_t;
    typedef logic [REM_W-1:0]         rem_t;
    typedef logic [DIV_CNT_W-1:0]     div_cnt_t;

    // register indexes
    localparam cfg_index_t REG_LIMIT_MODE    = 3'd0;
    localparam cfg_index_t REG_UPPER_LIMIT   = 3'd1;
    localparam cfg_index_t REG_LOWER_LIMIT   = 3'd2;
    localparam cfg_index_t REG_INITIAL_VALUE = 3'd3;
    localparam cfg_index_t REG_WINDOW_MODE   = 3'd4;
    localparam cfg_index_t REG_WINDOW_LENGTH = 3'd5;

    // limit modes
    localparam limit_t LIM_NONE = 2'd0;
    localparam limit_t LIM_SAT  = 2'd1;
    localparam limit_t LIM_WRAP = 2'd2;

    // command to the sample window
    typedef struct packed {
        logic  load;
        logic  pop;
        logic  push;
        data_t data;
    } win_cmd_t;

    // window status back to the core
    typedef struct packed {
        fill_t fill;
        data_t head_data;
    } win_stat_t;

    // wrap unit request and response
    typedef struct packed {
        logic  start;
        acc_t  acc;
        data_t bot;
        data_t top;
    } wrap_req_t;

    typedef struct packed {
        logic  done;
        data_t value;
    } wrap_rsp_t;

    // sign extension of a sample to accumulator width
    function automatic acc_t sext_data(input data_t v);
        return {{(ACC_W - DATA_W){v[DATA_W-1]}}, v};
    endfunction

endpackage

// ===== rtl/wii_ram.sv =====
// ============================================================================
// wii_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read (old data on a same-address write).
// ============================================================================
module wii_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/wii_window.sv =====
// ============================================================================
// wii_window
// Circular sample window: head pointer and fill count over the sample RAM,
// with the head entry read ahead every cycle and a same-cycle write forwarded.
// ============================================================================
module wii_window (
    input  logic               clk,
    input  logic               rst_n,
    input  wii_pkg::win_cmd_t  cmd,
    output wii_pkg::win_stat_t stat
);

    wii_pkg::addr_t head_reg, head_next, head_pop;
    wii_pkg::fill_t fill_reg, fill_next, fill_pop;
    wii_pkg::sum_t  wsum;
    wii_pkg::addr_t waddr;
    logic           we;
    logic           fwd_valid_reg, fwd_valid_next;
    wii_pkg::data_t fwd_data_reg;
    wii_pkg::data_t ram_rdata;

    // pointer update for the removal of the oldest sample
    always_comb
    begin
        head_pop = head_reg;
        fill_pop = fill_reg;
        if (cmd.pop)
        begin
            head_pop = (head_reg == wii_pkg::addr_t'(wii_pkg::WINDOW_DEPTH - 1))
                ? '0 : head_reg + wii_pkg::addr_t'(1);
            fill_pop = fill_reg - wii_pkg::fill_t'(1);
        end
    end

    // write slot after the newest sample, taken modulo the depth
    assign wsum  = wii_pkg::sum_t'(head_pop) + wii_pkg::sum_t'(fill_pop);
    assign waddr = cmd.load ? '0 :
        ((wsum >= wii_pkg::sum_t'(wii_pkg::WINDOW_DEPTH))
            ? wii_pkg::addr_t'(wsum - wii_pkg::sum_t'(wii_pkg::WINDOW_DEPTH))
            : wii_pkg::addr_t'(wsum));
    assign we    = cmd.load || cmd.push;

    // next head and fill
    always_comb
    begin
        head_next = head_pop;
        fill_next = fill_pop;
        if (cmd.load)
        begin
            head_next = '0;
            fill_next = wii_pkg::fill_t'(1);
        end
        else if (cmd.push)
        begin
            fill_next = fill_pop + wii_pkg::fill_t'(1);
        end
    end

    // forward a write that lands on the entry being read ahead
    assign fwd_valid_next = we && (waddr == head_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            fill_reg      <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= cmd.data;
    end

    // sample store, read at the next head every cycle
    wii_ram #(
        .WIDTH (wii_pkg::DATA_W),
        .DEPTH (wii_pkg::WINDOW_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (cmd.data),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    assign stat.fill      = fill_reg;
    assign stat.head_data = fwd_valid_reg ? fwd_data_reg : ram_rdata;

    // checks
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> fill_reg != '0)
        else $error("window pop with no sample held");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> fill_reg <= wii_pkg::fill_t'(wii_pkg::WINDOW_DEPTH))
        else $error("window fill beyond store depth");

endmodule

// ===== rtl/wii_wrap_div.sv =====
// ============================================================================
// wii_wrap_div
// Serial remainder unit for wrap mode: folds the accumulator into
// bot..top as bot + ((acc - bot) mod (top - bot + 1)), one bit per cycle.
// ============================================================================
module wii_wrap_div (
    input  logic               clk,
    input  logic               rst_n,
    input  wii_pkg::wrap_req_t req,
    output wii_pkg::wrap_rsp_t rsp
);

    typedef enum logic [3:0] {
        DV_IDLE = 4'b0001,
        DV_PREP = 4'b0010,
        DV_STEP = 4'b0100,
        DV_FIN  = 4'b1000
    } dv_state_t;

    dv_state_t          state_reg, state_next;
    wii_pkg::acc_t      hold_reg;
    wii_pkg::data_t     bot_reg;
    wii_pkg::data_t     top_reg;
    logic               neg_reg;
    logic [wii_pkg::ACC_W-1:0] dvd_reg;
    wii_pkg::rem_t      rem_reg, rem_next;
    wii_pkg::rem_t      div_reg;
    wii_pkg::div_cnt_t  cnt_reg;

    wii_pkg::wide_t     wa, wb, d_ab, d_ba;
    logic [wii_pkg::REM_W:0] rem_sh, trial;
    logic               ge;
    wii_pkg::rem_t      mod_val;
    logic [wii_pkg::REM_W:0] sum_val;

    // distance from the bottom, as sign and magnitude
    assign wa   = {hold_reg[wii_pkg::ACC_W-1], hold_reg};
    assign wb   = {{(wii_pkg::ACC_W + 1 - wii_pkg::DATA_W){bot_reg[wii_pkg::DATA_W-1]}},
                   bot_reg};
    assign d_ab = wa - wb;
    assign d_ba = wb - wa;

    // one restoring remainder step
    assign rem_sh = {rem_reg, dvd_reg[wii_pkg::ACC_W-1]};
    assign trial  = rem_sh - {1'b0, div_reg};
    assign ge     = rem_sh >= {1'b0, div_reg};
    assign rem_next = ge ? trial[wii_pkg::REM_W-1:0] : rem_sh[wii_pkg::REM_W-1:0];

    // fold a negative distance and add the bottom back
    assign mod_val = (neg_reg && (rem_reg != '0)) ? div_reg - rem_reg : rem_reg;
    assign sum_val = {{2{bot_reg[wii_pkg::DATA_W-1]}}, bot_reg} + {1'b0, mod_val};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DV_IDLE: if (req.start) state_next = DV_PREP;
            DV_PREP: state_next = DV_STEP;
            DV_STEP:
            begin
                if (cnt_reg == wii_pkg::div_cnt_t'(wii_pkg::ACC_W - 1))
                begin
                    state_next = DV_FIN;
                end
            end
            DV_FIN:  state_next = DV_IDLE;
            default: state_next = DV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == DV_IDLE && req.start)
        begin
            hold_reg <= req.acc;
            bot_reg  <= req.bot;
            top_reg  <= req.top;
        end
        if (state_reg == DV_PREP)
        begin
            neg_reg <= d_ab[wii_pkg::ACC_W];
            dvd_reg <= d_ab[wii_pkg::ACC_W] ? d_ba[wii_pkg::ACC_W-1:0]
                                            : d_ab[wii_pkg::ACC_W-1:0];
            div_reg <= {top_reg[wii_pkg::DATA_W-1], top_reg}
                     - {bot_reg[wii_pkg::DATA_W-1], bot_reg}
                     + wii_pkg::rem_t'(1);
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (state_reg == DV_STEP)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[wii_pkg::ACC_W-2:0], 1'b0};
            cnt_reg <= cnt_reg + wii_pkg::div_cnt_t'(1);
        end
    end

    assign rsp.done  = (state_reg == DV_FIN);
    assign rsp.value = sum_val[wii_pkg::DATA_W-1:0];

endmodule

// ===== rtl/wii_out_buf.sv =====
// ============================================================================
// wii_out_buf
// Output register with a skid stage, so a result can be taken in while the
// previous one is still stalled.
// ============================================================================
module wii_out_buf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           res_valid,
    input  wii_pkg::data_t res_data,
    output logic           out_valid,
    input  logic           out_stall,
    output wii_pkg::data_t integral,
    output logic           full
);

    logic           out_valid_reg, out_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    wii_pkg::data_t out_data_reg, out_data_next;
    wii_pkg::data_t skid_data_reg, skid_data_next;
    logic           free;

    assign free = !out_valid_reg || !out_stall;

    // refill the output register from the skid stage first
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = res_valid;
                skid_data_next  = res_data;
            end
            else
            begin
                out_valid_next = res_valid;
                out_data_next  = res_data;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign integral  = out_data_reg;
    assign full      = skid_valid_reg;

    // checks
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result ahead of an empty output");

endmodule

// ===== rtl/windowed_integer_integrator_core.sv =====
// outside a wrap, the result enters the output register or skid stage at the edge that takes the request
// one request per cycle while in_stall is low; a window shrink drops extra samples first
// wrap mode with the sum outside bot..top (lower not above upper): the serial unit runs its
// prepare, step and finish states, one remainder bit a cycle, while in_stall holds requests
// reset: accumulator, window head and fill cleared, window_length 100, other registers 0
// the sample store is not cleared; only entries written since the last load are read
// ============================================================================
// windowed_integer_integrator_core
// 64-bit running or sliding-window sum of signed samples with optional
// saturate or wrap limiting; the window samples sit in a single RAM.
// ============================================================================
module windowed_integer_integrator_core (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_write,
    input  wii_pkg::cfg_index_t        cfg_index,
    input  logic [wii_pkg::CFG_DATA_W-1:0] cfg_data,
    // sample request
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [wii_pkg::DATA_W-1:0] sample,
    input  logic                       restart,
    // result
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [wii_pkg::DATA_W-1:0] integral
);

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_WRAP = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    wii_pkg::limit_t     limit_mode_reg;
    wii_pkg::data_t      upper_limit_reg;
    wii_pkg::data_t      lower_limit_reg;
    wii_pkg::data_t      initial_value_reg;
    logic                window_mode_reg;
    wii_pkg::len_t       window_length_reg;
    wii_pkg::acc_t       acc_reg, acc_next;
    logic                started_reg, started_next;

    wii_pkg::win_cmd_t   win_cmd;
    wii_pkg::win_stat_t  win_stat;
    wii_pkg::wrap_req_t  wrap_req;
    wii_pkg::wrap_rsp_t  wrap_rsp;

    wii_pkg::cnt_t       len_ext, len_eff, keep, fill_ext;
    logic                plain_win, trim_now, accept, pop_acc, push_acc;
    logic                out_full;
    wii_pkg::acc_t       sx, hd_ext, add_term, sub_term, acc_pre;
    wii_pkg::acc_t       top_ext, bot_ext, sat_hi, sat_lo, acc_lim;
    logic                range_ok, in_range, wrap_need;
    logic                res_valid;
    wii_pkg::data_t      res_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_mode_reg    <= wii_pkg::LIM_NONE;
            upper_limit_reg   <= '0;
            lower_limit_reg   <= '0;
            initial_value_reg <= '0;
            window_mode_reg   <= 1'b0;
            window_length_reg <= wii_pkg::len_t'(wii_pkg::DEFAULT_WINDOW_LENGTH);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                wii_pkg::REG_LIMIT_MODE:
                    limit_mode_reg <= cfg_data[wii_pkg::LIMIT_W-1:0];
                wii_pkg::REG_UPPER_LIMIT:
                    upper_limit_reg <= cfg_data[wii_pkg::DATA_W-1:0];
                wii_pkg::REG_LOWER_LIMIT:
                    lower_limit_reg <= cfg_data[wii_pkg::DATA_W-1:0];
                wii_pkg::REG_INITIAL_VALUE:
                    initial_value_reg <= cfg_data[wii_pkg::DATA_W-1:0];
                wii_pkg::REG_WINDOW_MODE:
                    window_mode_reg <= cfg_data[0];
                wii_pkg::REG_WINDOW_LENGTH:
                    window_length_reg <= cfg_data[wii_pkg::LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // window length clipped to the store, and samples kept before the new one
    assign len_ext  = wii_pkg::cnt_t'(window_length_reg);
    assign len_eff  = (len_ext > wii_pkg::cnt_t'(wii_pkg::WINDOW_DEPTH))
                      ? wii_pkg::cnt_t'(wii_pkg::WINDOW_DEPTH) : len_ext;
    assign keep     = (len_eff == '0) ? '0 : len_eff - wii_pkg::cnt_t'(1);
    assign fill_ext = wii_pkg::cnt_t'(win_stat.fill);

    // handshake; extra oldest samples are dropped, one at a time, before the request is taken
    assign plain_win = started_reg && !restart && window_mode_reg;
    assign trim_now  = (state_reg == ST_RUN) && in_valid && plain_win
                       && (fill_ext > keep + wii_pkg::cnt_t'(1));
    assign in_stall  = (state_reg != ST_RUN) || out_full || trim_now;
    assign accept    = in_valid && !in_stall;
    assign pop_acc   = plain_win && (fill_ext > keep);
    assign push_acc  = plain_win && (len_eff != '0);

    // new accumulator value before limiting
    assign sx       = wii_pkg::sext_data(sample);
    assign hd_ext   = wii_pkg::sext_data(win_stat.head_data);
    assign add_term = (push_acc || !window_mode_reg) ? sx : '0;
    assign sub_term = pop_acc ? hd_ext : '0;

    always_comb
    begin
        if (!started_reg && !restart)
        begin
            acc_pre = wii_pkg::sext_data(initial_value_reg) + sx;
        end
        else if (restart)
        begin
            acc_pre = sx;
        end
        else
        begin
            acc_pre = acc_reg + add_term - sub_term;
        end
    end

    // limiting: saturate here, wrap only when the sum left the range
    assign top_ext  = wii_pkg::sext_data(upper_limit_reg);
    assign bot_ext  = wii_pkg::sext_data(lower_limit_reg);
    assign range_ok = upper_limit_reg >= lower_limit_reg;
    assign sat_hi   = (acc_pre > top_ext) ? top_ext : acc_pre;
    assign sat_lo   = (sat_hi < bot_ext) ? bot_ext : sat_hi;
    assign in_range = (acc_pre >= bot_ext) && (acc_pre <= top_ext);

    always_comb
    begin
        acc_lim   = acc_pre;
        wrap_need = 1'b0;
        case (limit_mode_reg)
            wii_pkg::LIM_SAT:  acc_lim = sat_lo;
            wii_pkg::LIM_WRAP: wrap_need = range_ok && !in_range;
            default:           acc_lim = acc_pre;
        endcase
    end

    // window commands
    always_comb
    begin
        win_cmd = '0;
        if (trim_now)
        begin
            win_cmd.pop = 1'b1;
        end
        else if (accept && window_mode_reg)
        begin
            win_cmd.data = sample;
            if (!started_reg || restart)
            begin
                win_cmd.load = 1'b1;
            end
            else
            begin
                win_cmd.pop  = pop_acc;
                win_cmd.push = push_acc;
            end
        end
    end

    // control and accumulator update
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        started_next   = started_reg;
        res_valid      = 1'b0;
        res_data       = acc_lim[wii_pkg::DATA_W-1:0];
        wrap_req.start = 1'b0;
        wrap_req.acc   = acc_pre;
        wrap_req.bot   = lower_limit_reg;
        wrap_req.top   = upper_limit_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (trim_now)
                begin
                    acc_next = acc_reg - hd_ext;
                end
                else if (accept)
                begin
                    started_next = 1'b1;
                    if (wrap_need)
                    begin
                        wrap_req.start = 1'b1;
                        state_next     = ST_WRAP;
                    end
                    else
                    begin
                        acc_next  = acc_lim;
                        res_valid = 1'b1;
                    end
                end
            end
            ST_WRAP:
            begin
                if (wrap_rsp.done)
                begin
                    acc_next   = wii_pkg::sext_data(wrap_rsp.value);
                    res_valid  = 1'b1;
                    res_data   = wrap_rsp.value;
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_RUN;
            acc_reg     <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            started_reg <= started_next;
        end
    end

    // sample window over the RAM
    wii_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (win_cmd),
        .stat  (win_stat)
    );

    // serial wrap unit
    wii_wrap_div u_wrap_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (wrap_req),
        .rsp   (wrap_rsp)
    );

    // result register and skid stage
    wii_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_data  (res_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .integral  (integral),
        .full      (out_full)
    );

    // checks
    a_wrap_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        wrap_rsp.done |-> state_reg == ST_WRAP)
        else $error("wrap unit finished outside a wrap request");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !wrap_req.start |=> out_valid)
        else $error("accepted request left no result");

endmodule

// ===== bench/windowed_integer_integrator_core_tb.sv =====
// ============================================================================
// windowed_integer_integrator_core_tb
// Drives sample requests through the integrator with random idle and stall
// bursts on both sides, and predicts most integrals from its own model of the
// running sum, the sliding sample window and the saturate and wrap limits.
// A short directed table, some rows of which fix the integral outright, comes first, then randomly configured phases.
// ============================================================================
module windowed_integer_integrator_core_tb;

    localparam int              CYCLE_LIMIT     = 2_000_000;
    localparam int              PHASES          = 14;
    localparam int              ITEMS_PER_PHASE = 125;
    localparam int              SETTLE_CYCLES   = 100;
    localparam wii_pkg::limit_t LIM_SPARE       = 2'd3;
    localparam wii_pkg::data_t  S_MAX           = 32'sh7FFF_FFFF;
    localparam wii_pkg::data_t  S_MIN           = 32'sh8000_0000;

    // one row of the directed table: a register write or a sample request
    typedef struct {
        bit                  is_write;
        wii_pkg::cfg_index_t idx;
        logic [31:0]         value;
        bit                  rst;
        bit                  known;
        wii_pkg::data_t      want;
    } step_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_write = 1'b0;
    wii_pkg::cfg_index_t            cfg_index = '0;
    logic [wii_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    wii_pkg::data_t                 sample    = '0;
    logic                           restart   = 1'b0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    wii_pkg::data_t                 integral;

    // register copies
    wii_pkg::limit_t reg_limit   = wii_pkg::LIM_NONE;
    wii_pkg::data_t  reg_upper   = '0;
    wii_pkg::data_t  reg_lower   = '0;
    wii_pkg::data_t  reg_initial = '0;
    logic            reg_window  = 1'b0;
    wii_pkg::len_t   reg_length  = wii_pkg::len_t'(wii_pkg::DEFAULT_WINDOW_LENGTH);

    // integrator state
    wii_pkg::acc_t   sum_acc     = '0;
    logic            seen_sample = 1'b0;
    wii_pkg::data_t  win_samples [wii_pkg::WINDOW_DEPTH];
    wii_pkg::addr_t  win_head    = '0;
    wii_pkg::fill_t  win_fill    = '0;

    wii_pkg::data_t  integral_q [$];
    step_t           plan_q [$];
    wii_pkg::data_t  got_want;
    bit              idle_on     = 1'b1;
    int              stall_left  = 0;
    int              errors      = 0;
    int              cycles      = 0;

    windowed_integer_integrator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .integral  (integral)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // expected integral for one sample, advancing the model state
    function automatic wii_pkg::data_t integrate_sample(input wii_pkg::data_t s, input bit r);
        wii_pkg::acc_t      sx;
        wii_pkg::acc_t      drop;
        wii_pkg::acc_t      bound;
        wii_pkg::fill_t     keep;
        logic signed [65:0] lo;
        logic signed [65:0] span;
        logic signed [65:0] offs;
        sx = wii_pkg::sext_data(s);
        if (!seen_sample || r)
        begin
            if (!seen_sample && !r)
            begin
                bound   = wii_pkg::sext_data(reg_initial);
                sum_acc = bound + sx;
            end
            else
                sum_acc = sx;
            // a load leaves only this sample in the window
            if (reg_window)
            begin
                win_head       = '0;
                win_samples[0] = s;
                win_fill       = wii_pkg::fill_t'(1);
            end
        end
        else
        begin
            sum_acc = sum_acc + sx;
            if (reg_window)
            begin
                keep = (reg_length > wii_pkg::WINDOW_DEPTH)
                       ? wii_pkg::fill_t'(wii_pkg::WINDOW_DEPTH)
                       : wii_pkg::fill_t'(reg_length);
                // drop oldest samples until the new one fits
                while (win_fill != 0 && win_fill >= keep)
                begin
                    drop     = wii_pkg::sext_data(win_samples[win_head]);
                    sum_acc  = sum_acc - drop;
                    win_head = wii_pkg::addr_t'(win_head + 1'b1);
                    win_fill = wii_pkg::fill_t'(win_fill - 1'b1);
                end
                if (keep == 0)
                    sum_acc = sum_acc - sx;
                else
                begin
                    win_samples[wii_pkg::addr_t'(win_head + win_fill)] = s;
                    win_fill = wii_pkg::fill_t'(win_fill + 1'b1);
                end
            end
        end
        seen_sample = 1'b1;
        // limiting
        case (reg_limit)
            wii_pkg::LIM_SAT:
            begin
                bound = wii_pkg::sext_data(reg_upper);
                if (sum_acc > bound)
                    sum_acc = bound;
                bound = wii_pkg::sext_data(reg_lower);
                if (sum_acc < bound)
                    sum_acc = bound;
            end
            wii_pkg::LIM_WRAP:
            begin
                if (reg_upper >= reg_lower)
                begin
                    lo   = reg_lower;
                    span = reg_upper;
                    span = span - lo + 66'sd1;
                    offs = sum_acc;
                    offs = (offs - lo) % span;
                    if (offs < 0)
                        offs = offs + span;
                    sum_acc = wii_pkg::acc_t'(lo + offs);
                end
            end
            default: ;
        endcase
        return wii_pkg::data_t'(sum_acc[wii_pkg::DATA_W-1:0]);
    endfunction

    function automatic wii_pkg::data_t pick_sample();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       return S_MAX;
                    1:       return S_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            1, 2:    return $urandom;
            default: return wii_pkg::data_t'($urandom_range(0, 400)) - 200;
        endcase
    endfunction

    // directed table rows
    task automatic plan_write(input wii_pkg::cfg_index_t idx, input logic [31:0] val);
        step_t row;
        row = '{is_write: 1'b1, idx: idx, value: val, rst: 1'b0,
                known: 1'b0, want: '0};
        plan_q.insert(plan_q.size(), row);
    endtask

    task automatic plan_item(input logic [31:0] s, input bit r);
        step_t row;
        row = '{is_write: 1'b0, idx: '0, value: s, rst: r,
                known: 1'b0, want: '0};
        plan_q.insert(plan_q.size(), row);
    endtask

    task automatic plan_check(input logic [31:0] s, input bit r, input wii_pkg::data_t want);
        step_t row;
        row = '{is_write: 1'b0, idx: '0, value: s, rst: r,
                known: 1'b1, want: want};
        plan_q.insert(plan_q.size(), row);
    endtask

    // register write, mirrored in the model at the write edge
    task automatic write_reg(input wii_pkg::cfg_index_t idx, input logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            wii_pkg::REG_LIMIT_MODE:    reg_limit   = val[wii_pkg::LIMIT_W-1:0];
            wii_pkg::REG_UPPER_LIMIT:   reg_upper   = val;
            wii_pkg::REG_LOWER_LIMIT:   reg_lower   = val;
            wii_pkg::REG_INITIAL_VALUE: reg_initial = val;
            wii_pkg::REG_WINDOW_MODE:   reg_window  = val[0];
            wii_pkg::REG_WINDOW_LENGTH: reg_length  = val[wii_pkg::LEN_W-1:0];
            default: ;
        endcase
    endtask

    // one sample request, with an optional idle burst ahead of it
    task automatic send_request(input wii_pkg::data_t s, input bit r, input bit known,
                                input wii_pkg::data_t lit);
        wii_pkg::data_t want;
        cfg_write <= 1'b0;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        restart  <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = integrate_sample(s, r);
        if (known)
            want = lit;
        integral_q.insert(integral_q.size(), want);
    endtask

    // wait until the block is idle before touching registers
    task automatic drain_results();
        in_valid <= 1'b0;
        while (integral_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // fresh random settings for one phase
    task automatic set_phase_regs();
        wii_pkg::data_t lo;
        wii_pkg::data_t hi;
        logic [31:0]    len;
        case ($urandom_range(0, 4))
            0:
            begin
                lo = -wii_pkg::data_t'($urandom_range(0, 2000));
                hi = $urandom_range(0, 2000);
            end
            1:
            begin
                lo = $urandom;
                hi = $urandom;
            end
            2:
            begin
                lo = S_MIN;
                hi = S_MAX;
            end
            3:
            begin
                hi = $urandom_range(0, 500);
                lo = hi + $urandom_range(1, 500);
            end
            default:
            begin
                lo = wii_pkg::data_t'($urandom_range(0, 200)) - 100;
                hi = lo;
            end
        endcase
        case ($urandom_range(0, 7))
            0:       len = 0;
            1:       len = wii_pkg::WINDOW_DEPTH;
            2:       len = (1 << wii_pkg::LEN_W) - 1;
            3:       len = $urandom_range(0, (1 << wii_pkg::LEN_W) - 1);
            default: len = $urandom_range(1, 40);
        endcase
        write_reg(wii_pkg::REG_LIMIT_MODE, $urandom_range(0, 3));
        write_reg(wii_pkg::REG_UPPER_LIMIT, hi);
        write_reg(wii_pkg::REG_LOWER_LIMIT, lo);
        write_reg(wii_pkg::REG_INITIAL_VALUE, $urandom);
        write_reg(wii_pkg::REG_WINDOW_MODE, 32'($urandom_range(0, 2) != 0));
        write_reg(wii_pkg::REG_WINDOW_LENGTH, len);
    endtask

    // receiver stall bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            stall_left <= $urandom_range(0, 8);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (integral_q.size() == 0)
            begin
                $error("unexpected result, integral %0d", integral);
                errors++;
            end
            else
            begin
                got_want = integral_q[0];
                integral_q.delete(0);
                if (integral !== got_want)
                begin
                    $error("integral: expected %0d, got %0d", got_want, integral);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("windowed_integer_integrator_core_tb failed");
            $finish;
        end
    end

    initial
    begin
        bit after_item;
        after_item = 1'b0;

        // zero-length window keeps only the initial value beside the load
        plan_write(wii_pkg::REG_INITIAL_VALUE, 1000);
        plan_write(wii_pkg::REG_WINDOW_MODE, 1);
        plan_write(wii_pkg::REG_WINDOW_LENGTH, 0);
        plan_check(7, 1'b0, 1007);
        plan_check(123, 1'b0, 1000);
        plan_check(-5, 1'b0, 1000);
        plan_check(9, 1'b1, 9);
        plan_check(4, 1'b0, 0);
        // short window, then one longer than the store
        plan_write(wii_pkg::REG_WINDOW_LENGTH, 2);
        plan_item(10, 1'b0);
        plan_item(20, 1'b0);
        plan_item(30, 1'b0);
        plan_write(wii_pkg::REG_WINDOW_LENGTH, (1 << wii_pkg::LEN_W) - 1);
        plan_item(S_MAX, 1'b0);
        plan_item(S_MAX, 1'b0);
        plan_item(S_MIN, 1'b0);
        // shrinking drops everything beyond the new length
        plan_write(wii_pkg::REG_WINDOW_LENGTH, 1);
        plan_item(1, 1'b0);
        // plain mode leaves the window as it was
        plan_write(wii_pkg::REG_WINDOW_MODE, 0);
        plan_item(100, 1'b0);
        plan_item(200, 1'b0);
        plan_write(wii_pkg::REG_WINDOW_MODE, 1);
        plan_item(5, 1'b0);
        // saturate, including lower above upper
        plan_write(wii_pkg::REG_LIMIT_MODE, 32'(wii_pkg::LIM_SAT));
        plan_write(wii_pkg::REG_UPPER_LIMIT, 50);
        plan_write(wii_pkg::REG_LOWER_LIMIT, -50);
        plan_check(S_MAX, 1'b1, 50);
        plan_check(S_MIN, 1'b1, -50);
        plan_write(wii_pkg::REG_LOWER_LIMIT, 100);
        plan_check(0, 1'b1, 100);
        // wrap, first with an empty range
        plan_write(wii_pkg::REG_LIMIT_MODE, 32'(wii_pkg::LIM_WRAP));
        plan_check(1000, 1'b1, 1000);
        plan_write(wii_pkg::REG_LOWER_LIMIT, -10);
        plan_write(wii_pkg::REG_UPPER_LIMIT, 9);
        plan_check(25, 1'b1, 5);
        plan_check(-11, 1'b1, 9);
        // spare limit code behaves as no limit
        plan_write(wii_pkg::REG_LIMIT_MODE, 32'(LIM_SPARE));
        plan_check(S_MAX, 1'b1, S_MAX);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (plan_q[i])
        begin
            if (plan_q[i].is_write)
            begin
                if (after_item)
                    drain_results();
                after_item = 1'b0;
                write_reg(plan_q[i].idx, plan_q[i].value);
            end
            else
            begin
                send_request(plan_q[i].value, plan_q[i].rst, plan_q[i].known,
                             plan_q[i].want);
                after_item = 1'b1;
            end
        end

        // random phases, the last one without idling
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            idle_on = (phase != PHASES - 1) && ($urandom_range(0, 4) != 0);
            set_phase_regs();
            repeat (ITEMS_PER_PHASE)
                send_request(pick_sample(), ($urandom_range(0, 19) == 0), 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (integral_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("windowed_integer_integrator_core_tb passed");
        else
            $display("windowed_integer_integrator_core_tb failed");
        $finish;
    end

endmodule
